@@ rtl/slr_pkg.sv @@
// shared types and constants for the shear line resampler
// no dependencies; imported by every module of the block
package slr_pkg;

  localparam int unsigned LINE_MAX     = 4096;
  localparam int unsigned FRAC_BITS_DEF = 14;
  localparam int unsigned POS_W        = 12;
  localparam int unsigned LEN_W        = 13;
  localparam int unsigned CH_W         = 8;
  localparam int unsigned SHEAR_W      = 16;
  localparam int unsigned DIFF_W       = POS_W + 1;
  localparam int unsigned PROD_W       = SHEAR_W + DIFF_W;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned DATA_W       = 56;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned LEN_CAP      = (LINE_MAX < 4096) ? LINE_MAX : 4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHEAR  = 2'd0,
    CFG_LENGTH = 2'd1,
    CFG_CENTER = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CH_W-1:0] a;
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } pixel_t;

  // one classified pixel on its way from front to back
  typedef struct packed {
    logic [POS_W-1:0]         line;
    logic [POS_W-1:0]         pos;
    pixel_t                   pix;
    logic                     first;
    logic                     last;
    logic signed [PROD_W-1:0] prod;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] dest;
    pixel_t           pix;
    logic             last;
  } result_t;

endpackage

@@ rtl/slr_front.sv @@
// front end: accepts pixels, drops those beyond the line, flags line start
// and end, and forms the shear product for the line start; uses slr_pkg
module slr_front (
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  logic [slr_pkg::POS_W-1:0]   line_i,
  input  logic [slr_pkg::POS_W-1:0]   pos_i,
  input  slr_pkg::pixel_t             pix_i,
  input  logic signed [slr_pkg::SHEAR_W-1:0] shear_i,
  input  logic [slr_pkg::LEN_W-1:0]   len_i,
  input  logic [slr_pkg::POS_W-1:0]   center_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output slr_pkg::item_t              item_o
);
  import slr_pkg::*;

  logic                     keep;
  logic signed [DIFF_W-1:0] diff;

  assign keep = {1'b0, pos_i} < len_i;
  assign diff = signed'({1'b0, line_i}) - signed'({1'b0, center_i});

  assign s_ready_o    = push_ready_i;
  assign push_valid_o = s_valid_i && keep;

  always_comb begin
    item_o.line  = line_i;
    item_o.pos   = pos_i;
    item_o.pix   = pix_i;
    item_o.first = (pos_i == '0);
    item_o.last  = ({1'b0, pos_i} == (len_i - LEN_W'(1)));
    item_o.prod  = PROD_W'(shear_i) * PROD_W'(diff);
  end

endmodule

@@ rtl/slr_queue.sv @@
// short fifo between front and back so each side stalls on its own
// uses slr_pkg for the item type and depth
module slr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           not_full_o,
  input  slr_pkg::item_t push_item_i,
  output logic           not_empty_o,
  input  logic           pop_i,
  output slr_pkg::item_t pop_item_o
);
  import slr_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign not_full_o  = cnt_q != (PTR_W+1)'(QUEUE_DEPTH);
  assign not_empty_o = cnt_q != '0;
  assign do_push     = push_i && not_full_o;
  assign do_pop      = pop_i && not_empty_o;
  assign pop_item_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PTR_W+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

@@ rtl/slr_back.sv @@
// back end: holds line shift, fraction and previous pixel, blends pairs, and
// places, range-checks and drains results, one per ready cycle; uses slr_pkg
module slr_back #(
  parameter int unsigned FRAC_BITS = slr_pkg::FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  output logic                      q_pop_o,
  input  slr_pkg::item_t            item_i,
  input  logic [slr_pkg::LEN_W-1:0] len_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output slr_pkg::result_t          res_o
);
  import slr_pkg::*;

  localparam int unsigned SHIFT_W = PROD_W - FRAC_BITS;
  localparam int unsigned DEST_W  = ((SHIFT_W > LEN_W) ? SHIFT_W : LEN_W) + 2;
  localparam int unsigned MIX_W   = CH_W + FRAC_BITS + 2;

  pixel_t                    prev_q, prev_d;
  logic signed [SHIFT_W-1:0] shift_q, shift_d;
  logic [FRAC_BITS-1:0]      frac_q, frac_d;
  result_t                   slot0_q, slot0_d, slot1_q, slot1_d;
  logic                      v0_q, v0_d, v1_q, v1_d;

  logic signed [SHIFT_W-1:0] new_shift, shift_use;
  logic signed [DEST_W-1:0]  pos_x, len_x, dest_pair, dest_copy;
  logic [FRAC_BITS:0]        one_m_f;
  logic [CH_W-1:0]           mix_ch [3];
  pixel_t                    pair_pix;
  logic                      k0, k1, out_fire, load_ok, load;

  assign new_shift = item_i.prod[PROD_W-1:FRAC_BITS];
  assign shift_use = item_i.first ? new_shift : shift_q;
  assign pos_x     = DEST_W'(signed'({1'b0, item_i.pos}));
  assign len_x     = DEST_W'(signed'({1'b0, len_i}));
  assign dest_copy = pos_x + DEST_W'(shift_use);
  assign dest_pair = dest_copy - DEST_W'(1);
  assign one_m_f   = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, frac_q};

  // linear blend of the red, green and blue channels, truncated
  always_comb begin
    logic [CH_W-1:0]  pch [3];
    logic [CH_W-1:0]  cch [3];
    logic [MIX_W-1:0] mix;
    pch[0] = prev_q.b;      pch[1] = prev_q.g;      pch[2] = prev_q.r;
    cch[0] = item_i.pix.b;  cch[1] = item_i.pix.g;  cch[2] = item_i.pix.r;
    for (int k = 0; k < 3; k++) begin
      mix = MIX_W'(pch[k]) * MIX_W'(one_m_f) + MIX_W'(cch[k]) * MIX_W'(frac_q);
      mix_ch[k] = mix[FRAC_BITS +: CH_W];
    end
  end

  always_comb begin
    if (prev_q.a == '0 && item_i.pix.a == '0) begin
      pair_pix = '0;
    end else if (prev_q.a == '0) begin
      pair_pix = item_i.pix;
    end else if (item_i.pix.a == '0) begin
      pair_pix = prev_q;
    end else begin
      pair_pix.a = '1;
      pair_pix.r = mix_ch[2];
      pair_pix.g = mix_ch[1];
      pair_pix.b = mix_ch[0];
    end
  end

  assign k0 = !item_i.first && (dest_pair >= 0) && (dest_pair < len_x);
  assign k1 = item_i.last && (dest_copy >= 0) && (dest_copy < len_x);

  assign res_valid_o = v0_q || v1_q;
  assign res_o       = v0_q ? slot0_q : slot1_q;
  assign out_fire    = res_valid_o && res_ready_i;
  // take a new item when no result is buffered or only one is and it is leaving
  assign load_ok     = !res_valid_o || (out_fire && !(v0_q && v1_q));
  assign load        = q_valid_i && load_ok;
  assign q_pop_o     = load;

  always_comb begin
    prev_d  = prev_q;
    shift_d = shift_q;
    frac_d  = frac_q;
    slot0_d = slot0_q;
    slot1_d = slot1_q;
    v0_d    = v0_q;
    v1_d    = v1_q;
    if (out_fire) begin
      if (v0_q) begin
        v0_d = 1'b0;
      end else begin
        v1_d = 1'b0;
      end
    end
    if (load) begin
      prev_d       = item_i.pix;
      if (item_i.first) begin
        shift_d = new_shift;
        frac_d  = item_i.prod[FRAC_BITS-1:0];
      end
      slot0_d.line = item_i.line;
      slot0_d.dest = dest_pair[POS_W-1:0];
      slot0_d.pix  = pair_pix;
      slot0_d.last = !k1;
      slot1_d.line = item_i.line;
      slot1_d.dest = dest_copy[POS_W-1:0];
      slot1_d.pix  = item_i.pix;
      slot1_d.last = 1'b1;
      v0_d         = k0;
      v1_d         = k1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q  <= '0;
      shift_q <= '0;
      frac_q  <= '0;
      v0_q    <= 1'b0;
      v1_q    <= 1'b0;
    end else begin
      prev_q  <= prev_d;
      shift_q <= shift_d;
      frac_q  <= frac_d;
      v0_q    <= v0_d;
      v1_q    <= v1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot0_q <= slot0_d;
    slot1_q <= slot1_d;
  end

endmodule

@@ rtl/shear_line_resampler_top.sv @@
// Shear line resampler: one shear pass of a three-shear rotation. Pixels of a
// line enter in position order, one per clock unless the queue is full; the
// pixel at position zero sets the line's integer shift and blend fraction.
// Each accepted pixel normally yields one result, the last of a line up to
// two, and results leave one per clock while the output is ready, so the
// sustained rate is one pixel per cycle except that a line end with a pair
// and a copy holds the next pixel until the pair leaves. Pixels pass the
// four-entry queue and result register. The user must write configuration
// through the cfg port only while the block is idle; it is not enforced.
// top level: config registers and slr_front/slr_queue/slr_back; uses slr_pkg
module shear_line_resampler_top #(
  parameter int unsigned FRAC_BITS = slr_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // line_index[11:0], position[23:12], alpha[31:24], red[39:32],
  // green[47:40], blue[55:48]
  input  logic [slr_pkg::DATA_W-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // out_line[11:0], dest_pos[23:12], out_alpha[31:24], out_red[39:32],
  // out_green[47:40], out_blue[55:48]
  output logic [slr_pkg::DATA_W-1:0]    m_axis_tdata,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [slr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [slr_pkg::SHEAR_W-1:0]   cfg_data_i
);
  import slr_pkg::*;

  logic signed [SHEAR_W-1:0] shear_q, shear_d;
  logic [LEN_W-1:0]          length_q, length_d;
  logic [POS_W-1:0]          center_q, center_d;
  logic [LEN_W-1:0]          len_eff;

  pixel_t  in_pix;
  item_t   push_item, pop_item;
  result_t res;
  logic    push_valid, q_not_full, q_not_empty, q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    shear_d  = shear_q;
    length_d = length_q;
    center_d = center_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SHEAR:  shear_d  = cfg_data_i;
        CFG_LENGTH: length_d = cfg_data_i[LEN_W-1:0];
        CFG_CENTER: center_d = cfg_data_i[POS_W-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shear_q  <= '0;
      length_q <= LEN_W'(4096);
      center_q <= '0;
    end else begin
      shear_q  <= shear_d;
      length_q <= length_d;
      center_q <= center_d;
    end
  end

  assign len_eff = (length_q > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : length_q;

  assign in_pix.a = s_axis_tdata[31:24];
  assign in_pix.r = s_axis_tdata[39:32];
  assign in_pix.g = s_axis_tdata[47:40];
  assign in_pix.b = s_axis_tdata[55:48];

  slr_front u_front (
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .line_i       (s_axis_tdata[11:0]),
    .pos_i        (s_axis_tdata[23:12]),
    .pix_i        (in_pix),
    .shear_i      (shear_q),
    .len_i        (len_eff),
    .center_i     (center_q),
    .push_valid_o (push_valid),
    .push_ready_i (q_not_full),
    .item_o       (push_item)
  );

  slr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_valid),
    .not_full_o  (q_not_full),
    .push_item_i (push_item),
    .not_empty_o (q_not_empty),
    .pop_i       (q_pop),
    .pop_item_o  (pop_item)
  );

  slr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_not_empty),
    .q_pop_o     (q_pop),
    .item_i      (pop_item),
    .len_i       (len_eff),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {res.pix.b, res.pix.g, res.pix.r, res.pix.a, res.dest, res.line};
  assign m_axis_tlast = res.last;

endmodule
